### hw/rtl/pfe_pkg.sv
package pfe_pkg;

   localparam int NUM_ROWS = 5;
   localparam int NUM_COLS = 5;
   localparam int CODE_W = 5;
   localparam int POS_W = 3;
   localparam int ROW_W = NUM_COLS * CODE_W;
   localparam int CSR_DATA_W = ROW_W;
   localparam int CSR_INDEX_W = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int MAX_LETTERS = 4;
   localparam int COUNT_W = 3;

   localparam logic [CODE_W-1:0] LETTER_X = 5'd23;
   localparam logic [CODE_W-1:0] LETTER_J = 5'd9;
   localparam logic [CODE_W-1:0] LETTER_I = 5'd8;
   localparam logic [CODE_W-1:0] LETTER_Q = 5'd16;

   localparam logic [7:0] ASCII_UPPER_A = 8'd65;
   localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
   localparam logic [7:0] ASCII_LOWER_A = 8'd97;
   localparam logic [7:0] ASCII_LOWER_Z = 8'd122;
   localparam logic [7:0] ASCII_CASE_OFFSET = 8'd32;
   localparam logic [6:0] ASCII_BASE = 7'd65;

   typedef logic [NUM_ROWS-1:0][ROW_W-1:0] grid_type;

   localparam grid_type GRID_RESET = {
      25'd27025109, 25'd21613104, 25'd16201099, 25'd10755269, 25'd4294688
   };

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_ROW_0  = 3'd0,
      CSR_GRID_ROW_1  = 3'd1,
      CSR_GRID_ROW_2  = 3'd2,
      CSR_GRID_ROW_3  = 3'd3,
      CSR_GRID_ROW_4  = 3'd4,
      CSR_MERGE_MODE  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_message;
   } in_item_type;

   typedef struct packed {
      logic [6:0] cipher_letter;
      logic       last_letter;
   } out_item_type;

   typedef struct packed {
      logic [CODE_W-1:0] first;
      logic [CODE_W-1:0] second;
   } pair_type;

   typedef struct packed {
      logic     two;
      pair_type p0;
      pair_type p1;
      logic     eom;
   } entry_type;

   typedef struct packed {
      logic       found;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } loc_type;

   function automatic logic [POS_W-1:0] inc5(input logic [POS_W-1:0] x);
      return (x == POS_W'(NUM_ROWS - 1)) ? '0 : POS_W'(x + 1'b1);
   endfunction

   function automatic logic [CODE_W-1:0] grid_cell(input grid_type g,
                                                    input logic [POS_W-1:0] row,
                                                    input logic [POS_W-1:0] col);
      return g[row][col*CODE_W +: CODE_W];
   endfunction

   // The scan runs backwards so that the first match in row-major order wins.
   function automatic loc_type grid_locate(input grid_type g,
                                           input logic [CODE_W-1:0] code);
      loc_type l;
      l = '0;
      for (int r = NUM_ROWS - 1; r >= 0; r--) begin
         for (int c = NUM_COLS - 1; c >= 0; c--) begin
            if (g[r][c*CODE_W +: CODE_W] == code) begin
               l.found = 1'b1;
               l.row = POS_W'(r);
               l.col = POS_W'(c);
            end
         end
      end
      return l;
   endfunction

endpackage

### hw/rtl/pfe_front.sv
module pfe_front
   import pfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        merge_mode,
   input  logic        accept,
   input  in_item_type item,
   output logic        enq_valid,
   output entry_type   enq_entry
);

   logic [CODE_W-1:0] raw_held_ff, raw_held_in;
   logic              raw_valid_ff, raw_valid_in;
   logic [CODE_W-1:0] prep_held_ff, prep_held_in;
   logic              prep_valid_ff, prep_valid_in;

   logic [7:0]        upper;
   logic              is_letter;
   logic [CODE_W-1:0] code;
   logic              keep;
   logic [CODE_W-1:0] seq [2];
   logic [1:0]        seq_n;
   logic [CODE_W-1:0] ph;
   logic              pv;
   logic [1:0]        np;
   pair_type          pairs [2];

   always_comb begin
      upper = item.char_in;
      if (item.char_in >= ASCII_LOWER_A && item.char_in <= ASCII_LOWER_Z) begin
         upper = item.char_in - ASCII_CASE_OFFSET;
      end
      is_letter = (upper >= ASCII_UPPER_A) && (upper <= ASCII_UPPER_Z);
      code = CODE_W'(upper - ASCII_UPPER_A);
      keep = is_letter;
      if (!merge_mode && code == LETTER_J) begin
         code = LETTER_I;
      end else if (merge_mode && code == LETTER_Q) begin
         keep = 1'b0;
      end

      seq[0] = code;
      seq[1] = code;
      seq_n = 2'd0;
      if (keep) begin
         if (raw_valid_ff && raw_held_ff == code) begin
            seq[0] = LETTER_X;
            seq_n = 2'd2;
         end else begin
            seq_n = 2'd1;
         end
      end

      ph = prep_held_ff;
      pv = prep_valid_ff;
      np = 2'd0;
      pairs[0] = '0;
      pairs[1] = '0;
      for (int k = 0; k < 2; k++) begin
         if (2'(k) < seq_n) begin
            if (!pv) begin
               ph = seq[k];
               pv = 1'b1;
            end else begin
               pairs[np[0]] = '{first: ph, second: seq[k]};
               np = np + 2'd1;
               pv = 1'b0;
            end
         end
      end
      if (item.end_of_message && pv) begin
         pairs[np[0]] = '{first: ph, second: LETTER_X};
         np = np + 2'd1;
         pv = 1'b0;
      end

      raw_held_in = raw_held_ff;
      raw_valid_in = raw_valid_ff;
      prep_held_in = prep_held_ff;
      prep_valid_in = prep_valid_ff;
      if (accept) begin
         if (item.end_of_message) begin
            raw_held_in = '0;
            raw_valid_in = 1'b0;
            prep_held_in = '0;
            prep_valid_in = 1'b0;
         end else begin
            if (keep) begin
               if (!raw_valid_ff) begin
                  raw_held_in = code;
                  raw_valid_in = 1'b1;
               end else begin
                  raw_valid_in = 1'b0;
               end
            end
            prep_held_in = ph;
            prep_valid_in = pv;
         end
      end

      enq_valid = accept && (np != 2'd0);
      enq_entry.two = (np == 2'd2);
      enq_entry.p0 = pairs[0];
      enq_entry.p1 = pairs[1];
      enq_entry.eom = item.end_of_message;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_held_ff <= '0;
         raw_valid_ff <= 1'b0;
         prep_held_ff <= '0;
         prep_valid_ff <= 1'b0;
      end else begin
         raw_held_ff <= raw_held_in;
         raw_valid_ff <= raw_valid_in;
         prep_held_ff <= prep_held_in;
         prep_valid_ff <= prep_valid_in;
      end
   end

endmodule

### hw/rtl/pfe_queue.sv
module pfe_queue
   import pfe_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output entry_type pop_data,
   output logic      empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
   endfunction

   assign full = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a push");

   assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (rd_ptr_ff != $past(rd_ptr_ff) || DEPTH == 1))
      else $error("queue read pointer did not advance");

endmodule

### hw/rtl/pfe_back.sv
module pfe_back
   import pfe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  grid_type     grid,
   input  logic         q_empty,
   input  entry_type    q_data,
   output logic         q_pop,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output out_item_type rsp_item
);

   typedef struct packed {
      logic    two;
      loc_type a0;
      loc_type b0;
      loc_type a1;
      loc_type b1;
      logic    eom;
   } located_type;

   logic              a_valid_ff, a_valid_in;
   entry_type         a_entry_ff;
   logic              b_valid_ff, b_valid_in;
   located_type       b_loc_ff, b_loc_in;
   logic [CODE_W-1:0] letters_ff [MAX_LETTERS];
   logic [CODE_W-1:0] letters_in [MAX_LETTERS];
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic              eom_ff, eom_in;

   logic              emit_ready, b_ready, a_ready, do_pop;
   logic              ok0, ok1;
   logic [CODE_W-1:0] c0a, c0b, c1a, c1b;

   function automatic logic [2*CODE_W-1:0] cipher(input grid_type g,
                                                  input loc_type x,
                                                  input loc_type y);
      logic [CODE_W-1:0] u, v;
      if (x.col == y.col) begin
         u = grid_cell(g, inc5(x.row), x.col);
         v = grid_cell(g, inc5(y.row), y.col);
      end else if (x.row == y.row) begin
         u = grid_cell(g, x.row, inc5(x.col));
         v = grid_cell(g, y.row, inc5(y.col));
      end else begin
         u = grid_cell(g, x.row, y.col);
         v = grid_cell(g, y.row, x.col);
      end
      return {u, v};
   endfunction

   assign do_pop = rsp_pop && (cnt_ff != '0);
   assign emit_ready = (cnt_ff == '0) || (do_pop && cnt_ff == COUNT_W'(1));
   assign b_ready = !b_valid_ff || emit_ready;
   assign a_ready = !a_valid_ff || b_ready;
   assign q_pop = a_ready && !q_empty;

   assign rsp_empty = (cnt_ff == '0);
   assign rsp_item.cipher_letter = {2'b00, letters_ff[0]} + ASCII_BASE;
   assign rsp_item.last_letter = eom_ff && (cnt_ff == COUNT_W'(1));

   always_comb begin
      a_valid_in = a_ready ? !q_empty : a_valid_ff;
      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;

      b_loc_in.two = a_entry_ff.two;
      b_loc_in.eom = a_entry_ff.eom;
      b_loc_in.a0 = grid_locate(grid, a_entry_ff.p0.first);
      b_loc_in.b0 = grid_locate(grid, a_entry_ff.p0.second);
      b_loc_in.a1 = grid_locate(grid, a_entry_ff.p1.first);
      b_loc_in.b1 = grid_locate(grid, a_entry_ff.p1.second);

      ok0 = b_loc_ff.a0.found && b_loc_ff.b0.found;
      ok1 = b_loc_ff.two && b_loc_ff.a1.found && b_loc_ff.b1.found;
      {c0a, c0b} = cipher(grid, b_loc_ff.a0, b_loc_ff.b0);
      {c1a, c1b} = cipher(grid, b_loc_ff.a1, b_loc_ff.b1);

      for (int i = 0; i < MAX_LETTERS; i++) begin
         letters_in[i] = letters_ff[i];
      end
      cnt_in = cnt_ff;
      eom_in = eom_ff;
      if (emit_ready) begin
         if (b_valid_ff) begin
            if (ok0) begin
               letters_in[0] = c0a;
               letters_in[1] = c0b;
               letters_in[2] = c1a;
               letters_in[3] = c1b;
            end else begin
               letters_in[0] = c1a;
               letters_in[1] = c1b;
               letters_in[2] = c1a;
               letters_in[3] = c1b;
            end
            cnt_in = COUNT_W'({ok0, 1'b0}) + COUNT_W'({ok1, 1'b0});
            eom_in = b_loc_ff.eom;
         end else begin
            cnt_in = '0;
         end
      end else if (do_pop) begin
         for (int i = 0; i < MAX_LETTERS - 1; i++) begin
            letters_in[i] = letters_ff[i+1];
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         cnt_ff <= '0;
         eom_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         cnt_ff <= cnt_in;
         eom_ff <= eom_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_entry_ff <= q_data;
      end
      if (b_ready) begin
         b_loc_ff <= b_loc_in;
      end
      for (int i = 0; i < MAX_LETTERS; i++) begin
         letters_ff[i] <= letters_in[i];
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= COUNT_W'(MAX_LETTERS))
      else $error("more letters pending than one item can give");

   assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !emit_ready) |=> (b_valid_ff && $stable(b_loc_ff)))
      else $error("located pair lost while the output was busy");

   assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !b_ready) |=> (a_valid_ff && $stable(a_entry_ff)))
      else $error("queued entry lost while the locate stage was busy");

   assert property (@(posedge clock) disable iff (reset)
      (do_pop && cnt_ff > COUNT_W'(1)) |=> (cnt_ff == $past(cnt_ff) - 1'b1))
      else $error("pending letter count did not follow a pop");

endmodule

### hw/rtl/playfair_stream_encrypt.sv
// Bytes are taken at one byte per cycle while they give no letters and the queue has room;
// the single result port then limits the rate to one letter per cycle while rsp_pop is held,
// so a byte giving four letters holds the result port until all four have been popped.
// A four-entry queue separates input filtering from grid lookup and output.
// Reset is synchronous and active high: it empties every stage, clears the held letters,
// loads the default grid and selects J-to-I merging.
module playfair_stream_encrypt
   import pfe_pkg::*;
#(
   parameter int QUEUE_ENTRIES = QUEUE_DEPTH
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  in_item_type            req_item,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output out_item_type           rsp_item,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   grid_type  grid_ff;
   logic      merge_mode_ff;
   logic      accept;
   logic      enq_valid;
   entry_type enq_entry;
   logic      q_full, q_empty, q_pop;
   entry_type q_data;

   assign req_full = q_full;
   assign accept = req_push && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff <= GRID_RESET;
         merge_mode_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_GRID_ROW_0: grid_ff[0] <= csr_wdata;
            CSR_GRID_ROW_1: grid_ff[1] <= csr_wdata;
            CSR_GRID_ROW_2: grid_ff[2] <= csr_wdata;
            CSR_GRID_ROW_3: grid_ff[3] <= csr_wdata;
            CSR_GRID_ROW_4: grid_ff[4] <= csr_wdata;
            CSR_MERGE_MODE: merge_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   pfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .merge_mode (merge_mode_ff),
      .accept     (accept),
      .item       (req_item),
      .enq_valid  (enq_valid),
      .enq_entry  (enq_entry)
   );

   pfe_queue #(
      .DEPTH (QUEUE_ENTRIES)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (enq_valid),
      .push_data (enq_entry),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   pfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .grid      (grid_ff),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule
